[rtl/core/s1mh_pkg.sv]
// Shared types and constants of the SHA-1 message hasher.
package s1mh_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam int unsigned NumChain = 5;
  localparam logic [2:0]  LastWordIdx = 3'(NumChain - 1);

  // Initial chaining values, H0 at index 0.
  localparam logic [NumChain-1:0][31:0] InitVals = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [5:0] LastPos   = 6'h3F;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

endpackage

[rtl/core/sha1_message_hasher_core.sv]
// SHA-1 message hasher: byte absorb, padding, iterative compression, digest output.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+------------------------------
//  byte     | in        | byte_valid / byte_stall     | byte_item   (mode, data_byte)
//  digest   | out       | digest_valid / digest_stall | digest_item (word, index, last)
//
// An absorb item is taken while the sequencer is idle. The 64th byte of a block starts a
// compression (load, 80 rounds on one shared round unit, add). A finish item puts in
// the pad byte, then the zero bytes plus one more step to move on to the length, then
// the 8 length bytes; it then runs one or two compressions and sends five digest
// items.
// byte_stall is high whenever the sequencer is away from idle.
// rst is synchronous and restores the initial chaining values and a zero byte count.
// A stalled digest item holds; the sequencer waits in the output state meanwhile.
module sha1_message_hasher_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  s1mh_pkg::msg_item_t    byte_item,
  output logic                   digest_valid,
  input  logic                   digest_stall,
  output s1mh_pkg::digest_item_t digest_item
);
  import s1mh_pkg::*;

  state_t state, state_next;
  state_t ret_state, ret_state_next;

  logic [NumChain-1:0][31:0] chain;
  logic [NumChain-1:0][31:0] wk;      // round registers a..e, a at index 0
  logic [511:0]              blk;     // message schedule, oldest word at the top
  logic [60:0]               count;
  logic [6:0]                rnd;
  logic [5:0]                pad_pos;
  logic [2:0]                word_idx;

  logic [5:0]  pos;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [31:0] w_cur;
  logic [31:0] w_new;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_sum;
  logic        in_take;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  assign pos      = count[5:0];
  assign len_bits = {count, 3'b000};
  // Length goes out big-endian; the low bits of pad_pos count the length bytes.
  assign len_byte = len_bits[{~pad_pos[2:0], 3'b000} +: 8];
  assign in_take  = byte_valid && !byte_stall;

  // Schedule taps: W[t], W[t+2], W[t+8], W[t+13].
  assign w_cur = blk[511:480];
  assign w_new = rotl(blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480], 1);

  always_comb begin
    if (rnd < 7'd20) begin
      f_val = (wk[1] & wk[2]) | (~wk[1] & wk[3]);
      k_val = K0;
    end else if (rnd < 7'd40) begin
      f_val = wk[1] ^ wk[2] ^ wk[3];
      k_val = K1;
    end else if (rnd < 7'd60) begin
      f_val = (wk[1] & wk[2]) | (wk[1] & wk[3]) | (wk[2] & wk[3]);
      k_val = K2;
    end else begin
      f_val = wk[1] ^ wk[2] ^ wk[3];
      k_val = K3;
    end
  end

  assign t_sum = rotl(wk[0], 5) + f_val + wk[4] + k_val + w_cur;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    unique case (state)
      ST_IDLE: begin
        if (byte_valid) begin
          if (byte_item.mode == MODE_FINISH) begin
            if (pos == LastPos) begin
              // Pad byte fills the block: compress, then pad a fresh one.
              state_next     = ST_LOAD;
              ret_state_next = ST_PAD;
            end else begin
              state_next = ST_PAD;
            end
          end else if (pos == LastPos) begin
            state_next     = ST_LOAD;
            ret_state_next = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        if (pad_pos == LenPos) begin
          state_next = ST_LEN;
        end else if (pad_pos == LastPos) begin
          state_next     = ST_LOAD;
          ret_state_next = ST_PAD;
        end
      end
      ST_LEN: begin
        if (pad_pos == LastPos) begin
          state_next     = ST_LOAD;
          ret_state_next = ST_OUT;
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (rnd == LastRound) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD:   state_next = ret_state;
      ST_OUT: begin
        if (!digest_stall && word_idx == LastWordIdx) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      chain    <= InitVals;
      wk       <= '0;
      count    <= '0;
      rnd      <= '0;
      pad_pos  <= '0;
      word_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (byte_item.mode == MODE_FINISH) begin
              blk     <= {blk[503:0], PadByte};
              pad_pos <= pos + 6'd1;
            end else begin
              blk   <= {blk[503:0], byte_item.data_byte};
              count <= count + 61'd1;
            end
          end
        end
        ST_PAD: begin
          if (pad_pos != LenPos) begin
            blk     <= {blk[503:0], 8'h00};
            pad_pos <= pad_pos + 6'd1;
          end
        end
        ST_LEN: begin
          blk     <= {blk[503:0], len_byte};
          pad_pos <= pad_pos + 6'd1;
        end
        ST_LOAD: begin
          wk  <= chain;
          rnd <= '0;
        end
        ST_ROUND: begin
          wk[4] <= wk[3];
          wk[3] <= wk[2];
          wk[2] <= rotl(wk[1], 30);
          wk[1] <= wk[0];
          wk[0] <= t_sum;
          blk   <= {blk[479:0], w_new};
          rnd   <= (rnd == LastRound) ? 7'd0 : rnd + 7'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < NumChain; i++) begin
            chain[i] <= chain[i] + wk[i];
          end
        end
        ST_OUT: begin
          if (!digest_stall) begin
            if (word_idx == LastWordIdx) begin
              // Drop the finished message and start over from the initial values.
              word_idx <= '0;
              chain    <= InitVals;
              count    <= '0;
            end else begin
              word_idx <= word_idx + 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign byte_stall              = (state != ST_IDLE);
  assign digest_valid            = (state == ST_OUT);
  assign digest_item.digest_word = chain[word_idx];
  assign digest_item.word_index  = word_idx;
  assign digest_item.last_word   = (word_idx == LastWordIdx);

endmodule

[rtl/core/s1mh_checker.sv]
// Port-level checks for the SHA-1 message hasher, bound to the top level.
module s1mh_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   byte_valid,
  input logic                   byte_stall,
  input s1mh_pkg::msg_item_t    byte_item,
  input logic                   digest_valid,
  input logic                   digest_stall,
  input s1mh_pkg::digest_item_t digest_item
);
  import s1mh_pkg::*;

  // Hold a stalled digest item.
  a_digest_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_stall |=> digest_valid && $stable(digest_item))
    else $error("digest item changed while stalled");

  // Take no byte while a digest is being delivered.
  a_no_take_in_out: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> byte_stall)
    else $error("input ready during digest output");

  // Flag the last word exactly at index four, never beyond.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (digest_item.last_word == (digest_item.word_index == LastWordIdx))
                     && (digest_item.word_index <= LastWordIdx))
    else $error("bad word index or last flag");

  // Close the digest after its last word.
  a_end_after_last: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_stall && digest_item.last_word |=> !digest_valid)
    else $error("digest output continued after last word");

  // Go busy right after a finish item.
  a_busy_after_finish: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && byte_item.mode == MODE_FINISH |=> byte_stall)
    else $error("not busy after finish item");

endmodule

bind sha1_message_hasher_core s1mh_checker u_s1mh_checker (.*);
